/* rtl/core/whc_pkg.sv */
// Shared types, constants and the arctangent table for the waypoint heading steering block.
`default_nettype none
package whc_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ATAN_ENTRIES      = 24;
   // datapath width of the rotation cells: dx*256 with headroom for gain and sign
   localparam int CORDIC_WIDTH      = 28;

   typedef enum logic [2:0] {
      CSR_ARRIVE_RADIUS = 3'd0,
      CSR_FORWARD_SPEED = 3'd1,
      CSR_TURN_RATE     = 3'd2,
      CSR_FACING_LIMIT  = 3'd3
   } csr_index_type;

   // per-item data that rides alongside the rotation chain
   typedef struct packed {
      logic [15:0] heading;
      logic        arrived;
   } side_type;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      logic [31:0] a;
      case (i)
         5'd0:    a = 32'h2000_0000;
         5'd1:    a = 32'h12E4_051E;
         5'd2:    a = 32'h09FB_385B;
         5'd3:    a = 32'h0511_11D4;
         5'd4:    a = 32'h028B_0D43;
         5'd5:    a = 32'h0145_D7E1;
         5'd6:    a = 32'h00A2_F61E;
         5'd7:    a = 32'h0051_7C55;
         5'd8:    a = 32'h0028_BE53;
         5'd9:    a = 32'h0014_5F2F;
         5'd10:   a = 32'h000A_2F98;
         5'd11:   a = 32'h0005_17CC;
         5'd12:   a = 32'h0002_8BE6;
         5'd13:   a = 32'h0001_45F3;
         5'd14:   a = 32'h0000_A2FA;
         5'd15:   a = 32'h0000_517D;
         5'd16:   a = 32'h0000_28BE;
         5'd17:   a = 32'h0000_145F;
         5'd18:   a = 32'h0000_0A30;
         5'd19:   a = 32'h0000_0518;
         5'd20:   a = 32'h0000_028C;
         5'd21:   a = 32'h0000_0146;
         5'd22:   a = 32'h0000_00A3;
         5'd23:   a = 32'h0000_0051;
         default: a = 32'h0000_0000;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/whc_front.sv */
// Front end: goal offset, half-plane fold and the registered arrival test.
`default_nettype none
module whc_front (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     in_valid,
   input  wire logic signed [15:0]                       pose_x,
   input  wire logic signed [15:0]                       pose_y,
   input  wire logic signed [15:0]                       pose_heading,
   input  wire logic signed [15:0]                       goal_x,
   input  wire logic signed [15:0]                       goal_y,
   input  wire logic [15:0]                              arrive_radius,
   output logic                                          out_valid,
   output logic signed [whc_pkg::CORDIC_WIDTH-1:0]       out_x,
   output logic signed [whc_pkg::CORDIC_WIDTH-1:0]       out_y,
   output logic [31:0]                                   out_z,
   output whc_pkg::side_type                             out_side
);
   import whc_pkg::*;

   localparam int CW = CORDIC_WIDTH;

   // stage 1: offsets
   logic               v1_ff;
   logic signed [16:0] dx_ff, dy_ff;
   logic [15:0]        head1_ff;
   // stage 2: folded vector and squares
   logic               v2_ff;
   logic signed [CW-1:0] x2_ff, y2_ff;
   logic [31:0]        z2_ff;
   logic [15:0]        head2_ff;
   logic [33:0]        sqx_ff, sqy_ff;
   logic [31:0]        r2_ff;
   // stage 3: arrival decision
   logic               v3_ff;
   logic signed [CW-1:0] x3_ff, y3_ff;
   logic [31:0]        z3_ff;
   side_type           side3_ff;

   logic signed [CW-1:0] xs_in, ys_in;
   logic signed [33:0]   sqx_in, sqy_in;
   logic [33:0]          d2_in;

   always_comb begin
      xs_in  = {{(CW-17){dx_ff[16]}}, dx_ff} <<< 8;
      ys_in  = {{(CW-17){dy_ff[16]}}, dy_ff} <<< 8;
      sqx_in = dx_ff * dx_ff;
      sqy_in = dy_ff * dy_ff;
      d2_in  = sqx_ff + sqy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      dx_ff    <= {goal_x[15], goal_x} - {pose_x[15], pose_x};
      dy_ff    <= {goal_y[15], goal_y} - {pose_y[15], pose_y};
      head1_ff <= pose_heading;

      // fold the left half plane onto the right by a half turn
      if (dx_ff[16]) begin
         x2_ff <= -xs_in;
         y2_ff <= -ys_in;
         z2_ff <= 32'h8000_0000;
      end else begin
         x2_ff <= xs_in;
         y2_ff <= ys_in;
         z2_ff <= 32'h0000_0000;
      end
      sqx_ff   <= sqx_in;
      sqy_ff   <= sqy_in;
      head2_ff <= head1_ff;
      r2_ff    <= arrive_radius * arrive_radius;

      x3_ff            <= x2_ff;
      y3_ff            <= y2_ff;
      z3_ff            <= z2_ff;
      side3_ff.heading <= head2_ff;
      side3_ff.arrived <= d2_in < {2'b00, r2_ff};
   end

   assign out_valid = v3_ff;
   assign out_x     = x3_ff;
   assign out_y     = y3_ff;
   assign out_z     = z3_ff;
   assign out_side  = side3_ff;

endmodule
`default_nettype wire

/* rtl/core/whc_cordic_cell.sv */
// One vectoring rotation cell of the arctangent chain.
`default_nettype none
module whc_cordic_cell #(
   parameter int STAGE = 0
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     in_valid,
   input  wire logic signed [whc_pkg::CORDIC_WIDTH-1:0]  in_x,
   input  wire logic signed [whc_pkg::CORDIC_WIDTH-1:0]  in_y,
   input  wire logic [31:0]                              in_z,
   input  wire whc_pkg::side_type                        in_side,
   output logic                                          out_valid,
   output logic signed [whc_pkg::CORDIC_WIDTH-1:0]       out_x,
   output logic signed [whc_pkg::CORDIC_WIDTH-1:0]       out_y,
   output logic [31:0]                                   out_z,
   output whc_pkg::side_type                             out_side
);
   import whc_pkg::*;

   localparam logic [31:0] ANGLE = atan_turn(5'(STAGE));

   logic                           valid_ff;
   logic signed [CORDIC_WIDTH-1:0] x_ff, y_ff, x_in, y_in, xsh, ysh;
   logic [31:0]                    z_ff, z_in;
   side_type                       side_ff;

   always_comb begin
      xsh = in_x >>> STAGE;
      ysh = in_y >>> STAGE;
      x_in = in_x;
      y_in = in_y;
      z_in = in_z;
      // rotate toward the x axis; a vector already on it stays put
      if (!in_y[CORDIC_WIDTH-1] && (in_y != '0)) begin
         x_in = in_x + ysh;
         y_in = in_y - xsh;
         z_in = in_z + ANGLE;
      end else if (in_y[CORDIC_WIDTH-1]) begin
         x_in = in_x - ysh;
         y_in = in_y + xsh;
         z_in = in_z - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule
`default_nettype wire

/* rtl/core/whc_steer.sv */
// Back end: bearing rounding, heading error wrap and the bang-bang commands.
`default_nettype none
module whc_steer (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [31:0]          in_z,
   input  wire whc_pkg::side_type    in_side,
   input  wire logic [15:0]          forward_speed,
   input  wire logic [14:0]          turn_rate,
   input  wire logic [14:0]          facing_limit,
   output logic                      out_valid,
   output logic                      out_arrived,
   output logic [15:0]               out_linear_cmd,
   output logic signed [15:0]        out_angular_cmd,
   output logic signed [15:0]        out_heading_error
);
   import whc_pkg::*;

   logic        va_ff;
   logic [15:0] bearing_ff;
   side_type    side_a_ff;
   logic [31:0] zr_in;

   logic        vb_ff;
   logic        arrived_ff;
   logic [15:0] linear_ff;
   logic [15:0] angular_ff;
   logic [15:0] error_ff;

   logic [15:0] err_in, mag_in, rate_in;
   logic        positive_in;

   always_comb begin
      zr_in       = in_z + 32'h0000_8000;
      err_in      = bearing_ff - side_a_ff.heading;
      // a half-turn error counts as positive
      positive_in = !err_in[15] || (err_in == 16'h8000);
      mag_in      = err_in[15] ? (~err_in + 16'd1) : err_in;
      rate_in     = {1'b0, turn_rate};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
      bearing_ff <= zr_in[31:16];
      side_a_ff  <= in_side;

      arrived_ff <= side_a_ff.arrived;
      if (side_a_ff.arrived) begin
         linear_ff  <= '0;
         angular_ff <= '0;
         error_ff   <= '0;
      end else begin
         linear_ff  <= (mag_in < {1'b0, facing_limit}) ? forward_speed : 16'd0;
         angular_ff <= positive_in ? rate_in : (~rate_in + 16'd1);
         error_ff   <= err_in;
      end
   end

   assign out_valid         = vb_ff;
   assign out_arrived       = arrived_ff;
   assign out_linear_cmd    = linear_ff;
   assign out_angular_cmd   = angular_ff;
   assign out_heading_error = error_ff;

endmodule
`default_nettype wire

/* rtl/core/waypoint_heading_steering.sv */
// Top level of the go-to-goal heading steering block.
// One item is taken in every clock cycle (busy stays low); its result appears on the rsp_
// ports, marked by rsp_valid for one cycle, once it has passed the registered stages: three
// front stages (offsets, fold and squares, arrival compare), one rotation cell per
// arctangent stage, and two back stages (bearing rounding, error and commands). The
// receiver cannot stall the block, so results must be taken as they come. Write the csr_
// registers only while no item is in flight; the new values apply to the next item.
`default_nettype none
module waypoint_heading_steering #(
   parameter int CORDIC_STAGES = whc_pkg::CORDIC_STAGES_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic signed [15:0]  req_pose_x,
   input  wire logic signed [15:0]  req_pose_y,
   input  wire logic signed [15:0]  req_pose_heading,
   input  wire logic signed [15:0]  req_goal_x,
   input  wire logic signed [15:0]  req_goal_y,
   output logic                     rsp_valid,
   output logic                     rsp_arrived,
   output logic [15:0]              rsp_linear_cmd,
   output logic signed [15:0]       rsp_angular_cmd,
   output logic signed [15:0]       rsp_heading_error,
   input  wire logic                csr_we,
   input  wire logic [2:0]          csr_addr,
   input  wire logic [15:0]         csr_wdata
);
   import whc_pkg::*;

   localparam int CW = CORDIC_WIDTH;

   logic [15:0] arrive_radius_ff, forward_speed_ff;
   logic [14:0] turn_rate_ff, facing_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         arrive_radius_ff <= 16'd128;
         forward_speed_ff <= 16'd512;
         turn_rate_ff     <= 15'd512;
         facing_limit_ff  <= 15'd8192;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_ARRIVE_RADIUS: arrive_radius_ff <= csr_wdata;
            CSR_FORWARD_SPEED: forward_speed_ff <= csr_wdata;
            CSR_TURN_RATE:     turn_rate_ff     <= csr_wdata[14:0];
            CSR_FACING_LIMIT:  facing_limit_ff  <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic                 chain_valid [CORDIC_STAGES+1];
   logic signed [CW-1:0] chain_x     [CORDIC_STAGES+1];
   logic signed [CW-1:0] chain_y     [CORDIC_STAGES+1];
   logic [31:0]          chain_z     [CORDIC_STAGES+1];
   side_type             chain_side  [CORDIC_STAGES+1];

   whc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (start),
      .pose_x       (req_pose_x),
      .pose_y       (req_pose_y),
      .pose_heading (req_pose_heading),
      .goal_x       (req_goal_x),
      .goal_y       (req_goal_y),
      .arrive_radius(arrive_radius_ff),
      .out_valid    (chain_valid[0]),
      .out_x        (chain_x[0]),
      .out_y        (chain_y[0]),
      .out_z        (chain_z[0]),
      .out_side     (chain_side[0])
   );

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      whc_cordic_cell #(.STAGE(g)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (chain_valid[g]),
         .in_x     (chain_x[g]),
         .in_y     (chain_y[g]),
         .in_z     (chain_z[g]),
         .in_side  (chain_side[g]),
         .out_valid(chain_valid[g+1]),
         .out_x    (chain_x[g+1]),
         .out_y    (chain_y[g+1]),
         .out_z    (chain_z[g+1]),
         .out_side (chain_side[g+1])
      );
   end

   whc_steer u_steer (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (chain_valid[CORDIC_STAGES]),
      .in_z             (chain_z[CORDIC_STAGES]),
      .in_side          (chain_side[CORDIC_STAGES]),
      .forward_speed    (forward_speed_ff),
      .turn_rate        (turn_rate_ff),
      .facing_limit     (facing_limit_ff),
      .out_valid        (rsp_valid),
      .out_arrived      (rsp_arrived),
      .out_linear_cmd   (rsp_linear_cmd),
      .out_angular_cmd  (rsp_angular_cmd),
      .out_heading_error(rsp_heading_error)
   );

endmodule
`default_nettype wire

/* rtl/core/whc_checker.sv */
// Port-level checks for the waypoint heading steering block, bound to the top level.
`default_nettype none
module whc_checker #(
   parameter int CORDIC_STAGES = whc_pkg::CORDIC_STAGES_DEF
) (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic               rsp_valid,
   input wire logic               rsp_arrived,
   input wire logic [15:0]        rsp_linear_cmd,
   input wire logic signed [15:0] rsp_angular_cmd,
   input wire logic signed [15:0] rsp_heading_error
);
   localparam int LATENCY = CORDIC_STAGES + 5;

   // every accepted item yields exactly one result after the fixed latency
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted item produced no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##LATENCY !rsp_valid)
      else $error("result without an accepted item");

   a_arrived_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_arrived) |->
         (rsp_linear_cmd == 16'd0) && (rsp_angular_cmd == 16'sd0)
         && (rsp_heading_error == 16'sd0))
      else $error("arrival with nonzero commands");

   // driving forward needs an error below a half turn
   a_drive_facing: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_arrived && (rsp_linear_cmd != 16'd0)) |->
         (rsp_heading_error != 16'sh8000))
      else $error("forward command at half-turn error");

endmodule

bind waypoint_heading_steering whc_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_whc_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_arrived      (rsp_arrived),
   .rsp_linear_cmd   (rsp_linear_cmd),
   .rsp_angular_cmd  (rsp_angular_cmd),
   .rsp_heading_error(rsp_heading_error)
);
`default_nettype wire
